/* hdl/swcf_pkg.sv */
// Shared types, constants and helpers of the shallow-water central face flux block.
// No dependencies; the front end, divider, back end and top module import this package.
package swcf_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS     = 16;
  localparam int DIV_STEPS     = 32;
  localparam logic [30:0] GRAVITY_RESET = 31'd642908;

  // Result status codes
  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_DRY = 2'd1;
  localparam logic [1:0] STATUS_SAT = 2'd2;

  // One restoring-division lane: partial remainder and dividend/quotient shifter
  typedef struct packed {
    logic [30:0] rem;
    logic [31:0] num;
  } lane_t;

  // Transaction state handed from the front end through the divider to the back end
  typedef struct packed {
    logic               dry;
    logic               neg_l;
    logic               neg_r;
    logic               over_l;
    logic               over_r;
    logic               gh_sat;
    logic [30:0]        ghavg;
    lane_t              lane_l;
    lane_t              lane_r;
    logic signed [31:0] hl;
    logic signed [31:0] mxl;
    logic signed [31:0] myl;
    logic signed [31:0] hr;
    logic signed [31:0] mxr;
    logic signed [31:0] myr;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
  } mid_t;

  // Saturation width: word width held within 16..32
  function automatic int sat_bits(int w);
    int r;
    r = w;
    if (w > 32) r = 32;
    if (w < 16) r = 16;
    return r;
  endfunction

  // Signed 32x32 product
  function automatic logic signed [63:0] mul_s32(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] ax;
    logic signed [63:0] bx;
    ax = 64'(a);
    bx = 64'(b);
    return ax * bx;
  endfunction

  // One quotient bit: shift in the next dividend bit, subtract if it fits
  function automatic lane_t div_step(lane_t x, logic [30:0] d);
    logic [31:0] t;
    lane_t       y;
    t = {x.rem, x.num[31]};
    if (t >= {1'b0, d}) begin
      y.rem = 31'(t - {1'b0, d});
      y.num = {x.num[30:0], 1'b1};
    end else begin
      y.rem = t[30:0];
      y.num = {x.num[30:0], 1'b0};
    end
    return y;
  endfunction

endpackage

/* hdl/swcf_if.sv */
// Valid/ready channel interfaces of the face flux block: face input and flux result.
// Depends on nothing.
interface swcf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_depth;
  logic signed [31:0] left_xmom;
  logic signed [31:0] left_ymom;
  logic signed [31:0] right_depth;
  logic signed [31:0] right_xmom;
  logic signed [31:0] right_ymom;
  logic signed [31:0] face_x;
  logic signed [31:0] face_y;

  modport source (output valid, left_depth, left_xmom, left_ymom, right_depth,
                  right_xmom, right_ymom, face_x, face_y, input ready);
  modport sink (input valid, left_depth, left_xmom, left_ymom, right_depth,
                right_xmom, right_ymom, face_x, face_y, output ready);
endinterface

interface swcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] flux_mass;
  logic signed [31:0] flux_xmom;
  logic signed [31:0] flux_ymom;
  logic [1:0]         status;

  modport source (output valid, flux_mass, flux_xmom, flux_ymom, status, input ready);
  modport sink (input valid, flux_mass, flux_xmom, flux_ymom, status, output ready);
endinterface

/* hdl/swcf_front.sv */
// Front end: momentum/normal products, dot products, depth squares, pressure term,
// and divider setup. Depends on swcf_pkg.
module swcf_front #(
  parameter int WORD_BITS = swcf_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [30:0]        gravity,
  input  logic               up_valid,
  output logic               up_ready,
  input  logic signed [31:0] left_depth,
  input  logic signed [31:0] left_xmom,
  input  logic signed [31:0] left_ymom,
  input  logic signed [31:0] right_depth,
  input  logic signed [31:0] right_xmom,
  input  logic signed [31:0] right_ymom,
  input  logic signed [31:0] face_x,
  input  logic signed [31:0] face_y,
  output logic               dn_valid,
  input  logic               dn_ready,
  output swcf_pkg::mid_t     dn_data
);
  import swcf_pkg::*;

  localparam int NST = 4;
  localparam int SAT_BITS = sat_bits(WORD_BITS);
  localparam logic [61:0] GH_MAX = 62'((64'd1 << (SAT_BITS - 1)) - 64'd1);

  typedef struct packed {
    logic signed [31:0] hl, mxl, myl, hr, mxr, myr, sx, sy;
  } face_t;

  typedef struct packed {
    logic               dry;
    logic signed [63:0] pxl, pyl, pxr, pyr;
    logic [63:0]        sql, sqr;
    face_t              f;
  } s1_t;

  typedef struct packed {
    logic        dry;
    logic        neg_l, neg_r;
    logic [47:0] mag_l, mag_r;
    logic [47:0] s;
    face_t       f;
  } s2_t;

  typedef struct packed {
    logic        dry;
    logic        neg_l, neg_r, over_l, over_r;
    lane_t       lane_l, lane_r;
    logic [54:0] ga, gb;
    face_t       f;
  } s3_t;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  mid_t s4_r, s4_nxt;
  logic signed [48:0] dot_l, dot_r;
  logic [61:0]        gh_v;

  // Elastic stage enables: a stage loads when empty or when it drains
  always_comb begin
    en[NST-1] = !v_r[NST-1] || dn_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end
  assign up_ready = en[0];
  assign dn_valid = v_r[NST-1];
  assign dn_data  = s4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) v_r[i] <= (i == 0) ? up_valid : v_r[i-1];
      end
    end
  end

  // Stage 1: all input products
  always_comb begin
    s1_nxt.dry = left_depth[31] || (left_depth == '0) || right_depth[31] || (right_depth == '0);
    s1_nxt.pxl = mul_s32(left_xmom, face_x);
    s1_nxt.pyl = mul_s32(left_ymom, face_y);
    s1_nxt.pxr = mul_s32(right_xmom, face_x);
    s1_nxt.pyr = mul_s32(right_ymom, face_y);
    s1_nxt.sql = mul_s32(left_depth, left_depth);
    s1_nxt.sqr = mul_s32(right_depth, right_depth);
    s1_nxt.f   = '{left_depth, left_xmom, left_ymom, right_depth, right_xmom,
                   right_ymom, face_x, face_y};
  end

  // Stage 2: dot products to sign/magnitude, sum of squared depths
  always_comb begin
    dot_l = 49'(s1_r.pxl >>> FRAC_BITS) + 49'(s1_r.pyl >>> FRAC_BITS);
    dot_r = 49'(s1_r.pxr >>> FRAC_BITS) + 49'(s1_r.pyr >>> FRAC_BITS);
    s2_nxt.dry   = s1_r.dry;
    s2_nxt.neg_l = dot_l[48];
    s2_nxt.neg_r = dot_r[48];
    s2_nxt.mag_l = dot_l[48] ? 48'(-dot_l) : 48'(dot_l);
    s2_nxt.mag_r = dot_r[48] ? 48'(-dot_r) : 48'(dot_r);
    s2_nxt.s     = s1_r.sql[63:16] + s1_r.sqr[63:16];
    s2_nxt.f     = s1_r.f;
  end

  // Stage 3: gravity partial products, quotient range check, divider lanes
  always_comb begin
    s3_nxt.dry    = s2_r.dry;
    s3_nxt.neg_l  = s2_r.neg_l;
    s3_nxt.neg_r  = s2_r.neg_r;
    s3_nxt.over_l = s2_r.mag_l[47:16] >= {1'b0, s2_r.f.hl[30:0]};
    s3_nxt.over_r = s2_r.mag_r[47:16] >= {1'b0, s2_r.f.hr[30:0]};
    s3_nxt.lane_l = '{s2_r.mag_l[46:16], {s2_r.mag_l[15:0], 16'h0}};
    s3_nxt.lane_r = '{s2_r.mag_r[46:16], {s2_r.mag_r[15:0], 16'h0}};
    s3_nxt.ga     = {24'h0, gravity} * {31'h0, s2_r.s[47:24]};
    s3_nxt.gb     = {24'h0, gravity} * {31'h0, s2_r.s[23:0]};
    s3_nxt.f      = s2_r.f;
  end

  // Stage 4: pressure coefficient g/4 * S with saturation
  always_comb begin
    gh_v = {1'b0, s3_r.ga, 6'h0} + 62'(s3_r.gb[54:18]);
    s4_nxt.dry    = s3_r.dry;
    s4_nxt.neg_l  = s3_r.neg_l;
    s4_nxt.neg_r  = s3_r.neg_r;
    s4_nxt.over_l = s3_r.over_l;
    s4_nxt.over_r = s3_r.over_r;
    s4_nxt.gh_sat = gh_v > GH_MAX;
    s4_nxt.ghavg  = (gh_v > GH_MAX) ? GH_MAX[30:0] : gh_v[30:0];
    s4_nxt.lane_l = s3_r.lane_l;
    s4_nxt.lane_r = s3_r.lane_r;
    s4_nxt.hl     = s3_r.f.hl;
    s4_nxt.mxl    = s3_r.f.mxl;
    s4_nxt.myl    = s3_r.f.myl;
    s4_nxt.hr     = s3_r.f.hr;
    s4_nxt.mxr    = s3_r.f.mxr;
    s4_nxt.myr    = s3_r.f.myr;
    s4_nxt.sx     = s3_r.f.sx;
    s4_nxt.sy     = s3_r.f.sy;
  end

  always_ff @(posedge clk) begin
    if (en[0]) s1_r <= s1_nxt;
    if (en[1]) s2_r <= s2_nxt;
    if (en[2]) s3_r <= s3_nxt;
    if (en[3]) s4_r <= s4_nxt;
  end

endmodule

/* hdl/swcf_div.sv */
// Pipelined restoring divider: one quotient bit per stage for both normal velocities.
// Depends on swcf_pkg.
module swcf_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  swcf_pkg::mid_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output swcf_pkg::mid_t dn_data
);
  import swcf_pkg::*;

  localparam int NST = DIV_STEPS;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;
  mid_t           st_r   [NST];
  mid_t           st_nxt [NST];

  // Elastic stage enables
  always_comb begin
    en[NST-1] = !v_r[NST-1] || dn_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end
  assign up_ready = en[0];
  assign dn_valid = v_r[NST-1];
  assign dn_data  = st_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) v_r[i] <= (i == 0) ? up_valid : v_r[i-1];
      end
    end
  end

  // Each stage retires one quotient bit on both lanes
  for (genvar g = 0; g < NST; g++) begin : g_step
    mid_t src;
    assign src = (g == 0) ? up_data : st_r[(g == 0) ? 0 : g - 1];
    always_comb begin
      st_nxt[g]        = src;
      st_nxt[g].lane_l = div_step(src.lane_l, src.hl[30:0]);
      st_nxt[g].lane_r = div_step(src.lane_r, src.hr[30:0]);
    end
    always_ff @(posedge clk) begin
      if (en[g]) st_r[g] <= st_nxt[g];
    end
  end

endmodule

/* hdl/swcf_back.sv */
// Back end: normal-velocity saturation, flux products, averaging, final saturation
// and status. Depends on swcf_pkg.
module swcf_back #(
  parameter int WORD_BITS = swcf_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  swcf_pkg::mid_t     up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output logic signed [31:0] flux_mass,
  output logic signed [31:0] flux_xmom,
  output logic signed [31:0] flux_ymom,
  output logic [1:0]         status
);
  import swcf_pkg::*;

  localparam int NST = 4;
  localparam int SAT_BITS = sat_bits(WORD_BITS);
  localparam logic [32:0] QS_HI = 33'((64'd1 << (SAT_BITS - 1)) - 64'd1);
  localparam logic signed [48:0] FLUX_HI = (49'sd1 <<< (SAT_BITS - 1)) - 49'sd1;
  localparam logic signed [48:0] FLUX_LO = -FLUX_HI - 49'sd1;

  typedef struct packed {
    logic               dry, sat;
    logic signed [31:0] qsl, qsr;
    logic [30:0]        ghavg;
    logic signed [31:0] hl, mxl, myl, hr, mxr, myr, sx, sy;
  } b1_t;

  typedef struct packed {
    logic               dry, sat;
    logic signed [63:0] m0l, m0r, m1l, m1r, m2l, m2r, p1, p2;
  } b2_t;

  typedef struct packed {
    logic               dry, sat;
    logic signed [47:0] c0, c1, c2, pr1, pr2;
  } b3_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] val;
  } clip_t;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;
  b1_t  b1_r, b1_nxt;
  b2_t  b2_r, b2_nxt;
  b3_t  b3_r, b3_nxt;
  logic signed [31:0] fm_r, fx_r, fy_r, fm_nxt, fx_nxt, fy_nxt;
  logic [1:0]         st_r, st_nxt;
  logic [32:0]        lim_l, lim_r, q_l, q_r;
  logic               sat_l, sat_r;
  clip_t              k0, k1, k2;

  function automatic logic signed [47:0] conv(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [48:0] t;
    t = 49'(a >>> FRAC_BITS) + 49'(b >>> FRAC_BITS);
    return 48'(t >>> 1);
  endfunction

  function automatic clip_t clip(logic signed [47:0] c, logic signed [47:0] p);
    logic signed [48:0] t;
    clip_t              r;
    t = 49'(c) + 49'(p);
    r.hit = (t > FLUX_HI) || (t < FLUX_LO);
    if (t > FLUX_HI) r.val = 32'(FLUX_HI);
    else if (t < FLUX_LO) r.val = 32'(FLUX_LO);
    else r.val = 32'(t);
    return r;
  endfunction

  // Elastic stage enables
  always_comb begin
    en[NST-1] = !v_r[NST-1] || dn_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end
  assign up_ready  = en[0];
  assign dn_valid  = v_r[NST-1];
  assign flux_mass = fm_r;
  assign flux_xmom = fx_r;
  assign flux_ymom = fy_r;
  assign status    = st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) v_r[i] <= (i == 0) ? up_valid : v_r[i-1];
      end
    end
  end

  // Stage 1: clamp quotient magnitudes, apply sign
  always_comb begin
    lim_l = QS_HI + 33'(up_data.neg_l);
    lim_r = QS_HI + 33'(up_data.neg_r);
    sat_l = up_data.over_l || ({1'b0, up_data.lane_l.num} > lim_l);
    sat_r = up_data.over_r || ({1'b0, up_data.lane_r.num} > lim_r);
    q_l   = sat_l ? lim_l : {1'b0, up_data.lane_l.num};
    q_r   = sat_r ? lim_r : {1'b0, up_data.lane_r.num};
    b1_nxt.dry   = up_data.dry;
    b1_nxt.sat   = sat_l || sat_r || up_data.gh_sat;
    b1_nxt.qsl   = up_data.neg_l ? 32'(-q_l) : 32'(q_l);
    b1_nxt.qsr   = up_data.neg_r ? 32'(-q_r) : 32'(q_r);
    b1_nxt.ghavg = up_data.ghavg;
    b1_nxt.hl    = up_data.hl;
    b1_nxt.mxl   = up_data.mxl;
    b1_nxt.myl   = up_data.myl;
    b1_nxt.hr    = up_data.hr;
    b1_nxt.mxr   = up_data.mxr;
    b1_nxt.myr   = up_data.myr;
    b1_nxt.sx    = up_data.sx;
    b1_nxt.sy    = up_data.sy;
  end

  // Stage 2: convective and pressure products
  always_comb begin
    b2_nxt.dry = b1_r.dry;
    b2_nxt.sat = b1_r.sat;
    b2_nxt.m0l = mul_s32(b1_r.qsl, b1_r.hl);
    b2_nxt.m0r = mul_s32(b1_r.qsr, b1_r.hr);
    b2_nxt.m1l = mul_s32(b1_r.qsl, b1_r.mxl);
    b2_nxt.m1r = mul_s32(b1_r.qsr, b1_r.mxr);
    b2_nxt.m2l = mul_s32(b1_r.qsl, b1_r.myl);
    b2_nxt.m2r = mul_s32(b1_r.qsr, b1_r.myr);
    b2_nxt.p1  = mul_s32({1'b0, b1_r.ghavg}, b1_r.sx);
    b2_nxt.p2  = mul_s32({1'b0, b1_r.ghavg}, b1_r.sy);
  end

  // Stage 3: average left/right terms, scale pressure
  always_comb begin
    b3_nxt.dry = b2_r.dry;
    b3_nxt.sat = b2_r.sat;
    b3_nxt.c0  = conv(b2_r.m0l, b2_r.m0r);
    b3_nxt.c1  = conv(b2_r.m1l, b2_r.m1r);
    b3_nxt.c2  = conv(b2_r.m2l, b2_r.m2r);
    b3_nxt.pr1 = 48'(b2_r.p1 >>> FRAC_BITS);
    b3_nxt.pr2 = 48'(b2_r.p2 >>> FRAC_BITS);
  end

  // Stage 4: final sum, saturation, dry override
  always_comb begin
    k0 = clip(b3_r.c0, 48'sd0);
    k1 = clip(b3_r.c1, b3_r.pr1);
    k2 = clip(b3_r.c2, b3_r.pr2);
    if (b3_r.dry) begin
      fm_nxt = '0;
      fx_nxt = '0;
      fy_nxt = '0;
      st_nxt = STATUS_DRY;
    end else begin
      fm_nxt = k0.val;
      fx_nxt = k1.val;
      fy_nxt = k2.val;
      st_nxt = (b3_r.sat || k0.hit || k1.hit || k2.hit) ? STATUS_SAT : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) b1_r <= b1_nxt;
    if (en[1]) b2_r <= b2_nxt;
    if (en[2]) b3_r <= b3_nxt;
    if (en[3]) begin
      fm_r <= fm_nxt;
      fx_r <= fx_nxt;
      fy_r <= fy_nxt;
      st_r <= st_nxt;
    end
  end

endmodule

/* hdl/shallow_water_central_face_flux.sv */
// Central convective flux of the 2D shallow-water equations through one cell face.
// Depends on swcf_pkg, swcf_if, swcf_front, swcf_div and swcf_back.
//
// Usage:
//   in_ch  (sink)  : one face per transaction - left/right depth and momenta and the
//                    scaled face normal, all signed Q16.16.
//   out_ch (source): one result per face - mass, x and y momentum flux (Q16.16,
//                    saturated) and status (ok, dry, saturated), in input order.
//   cfg_wr_en/cfg_wr_data: write the gravity register (unsigned Q16.16); write it
//                    only while no face is in flight.
// Throughput is one face per cycle while out_ch.ready is high. A face passes from
// acceptance to out_ch.valid through 4 front-end stages (products, dot, pressure),
// 32 divider stages (one quotient bit each for both velocities), 4 back-end stages.
// Every stage is elastic: when out_ch.ready is low, items pack into empty stages
// and in_ch.ready drops only once the whole pipeline is full; nothing is lost.
// Reset (rst_n low, synchronous) empties the pipeline and sets gravity to 9.81.
module shallow_water_central_face_flux #(
  parameter int WORD_BITS = swcf_pkg::WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  swcf_in_if.sink     in_ch,
  swcf_out_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic [30:0] cfg_wr_data
);
  import swcf_pkg::*;

  logic [30:0]    gravity_r;
  logic           f2d_valid, f2d_ready, d2b_valid, d2b_ready;
  mid_t           f2d_data, d2b_data;

  // Gravity configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r <= GRAVITY_RESET;
    end else if (cfg_wr_en) begin
      gravity_r <= cfg_wr_data;
    end
  end

  swcf_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .gravity     (gravity_r),
    .up_valid    (in_ch.valid),
    .up_ready    (in_ch.ready),
    .left_depth  (in_ch.left_depth),
    .left_xmom   (in_ch.left_xmom),
    .left_ymom   (in_ch.left_ymom),
    .right_depth (in_ch.right_depth),
    .right_xmom  (in_ch.right_xmom),
    .right_ymom  (in_ch.right_ymom),
    .face_x      (in_ch.face_x),
    .face_y      (in_ch.face_y),
    .dn_valid    (f2d_valid),
    .dn_ready    (f2d_ready),
    .dn_data     (f2d_data)
  );

  swcf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f2d_valid),
    .up_ready (f2d_ready),
    .up_data  (f2d_data),
    .dn_valid (d2b_valid),
    .dn_ready (d2b_ready),
    .dn_data  (d2b_data)
  );

  swcf_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (d2b_valid),
    .up_ready  (d2b_ready),
    .up_data   (d2b_data),
    .dn_valid  (out_ch.valid),
    .dn_ready  (out_ch.ready),
    .flux_mass (out_ch.flux_mass),
    .flux_xmom (out_ch.flux_xmom),
    .flux_ymom (out_ch.flux_ymom),
    .status    (out_ch.status)
  );

  // A dry face carries zero flux
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == STATUS_DRY) |->
      (out_ch.flux_mass == '0) && (out_ch.flux_xmom == '0) && (out_ch.flux_ymom == '0))
    else $error("dry result with nonzero flux");

  // Status never takes the unused code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status == STATUS_OK) || (out_ch.status == STATUS_DRY) ||
                     (out_ch.status == STATUS_SAT))
    else $error("illegal status code");

  // A configuration write lands in the gravity register
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> gravity_r == $past(cfg_wr_data))
    else $error("gravity write lost");

endmodule
